// ===== design/double_buffer_blit_diff_flush_core_assert.svh =====
// Assertion macros shared by the double-buffer blitter RTL.
// Expects signals named clk and rst in the including module.
`ifndef DOUBLE_BUFFER_BLIT_DIFF_FLUSH_CORE_ASSERT_SVH
`define DOUBLE_BUFFER_BLIT_DIFF_FLUSH_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define DBF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dbf_pkg.sv =====
// Package for the double-buffer blitter: screen geometry, codes and types.
// No dependencies; every other design file but the assertion macro header uses it by scoped names.
package dbf_pkg;

  localparam int SCREEN_COLUMNS  = 640;
  localparam int SCREEN_ROWS     = 480;
  localparam int SPRITE_SIDE_MAX = 256;

  localparam int PIXEL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(PIXEL_COUNT);
  localparam int COL_W       = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W       = $clog2(SCREEN_ROWS);

  localparam int REQ_W      = 2;
  localparam int POS_W      = 11;
  localparam int OFF_W      = 8;
  localparam int COLOR_W    = 8;
  localparam int OUT_ADDR_W = 19;
  // Signed work width for origin plus offset.
  localparam int SUM_W      = POS_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ADDR_W-1:0]     pix_addr_t;
  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [OUT_ADDR_W-1:0] out_addr_t;
  typedef logic [REQ_W-1:0]      req_type_t;
  typedef logic [1:0]            cmd_op_t;

  localparam color_t    KEY_COLOR = 8'd255;
  localparam pix_addr_t LAST_ADDR = pix_addr_t'(PIXEL_COUNT - 1);

  // Request codes on the input channel.
  localparam req_type_t REQ_CLEAR  = 2'd0;
  localparam req_type_t REQ_PIXEL  = 2'd1;
  localparam req_type_t REQ_SPRITE = 2'd2;
  localparam req_type_t REQ_SCAN   = 2'd3;

  // Command codes between front and back.
  localparam cmd_op_t CMD_CLEAR = 2'd0;
  localparam cmd_op_t CMD_PIXEL = 2'd1;
  localparam cmd_op_t CMD_SCAN  = 2'd2;

  typedef struct packed {
    cmd_op_t   op;
    pix_addr_t addr;
    color_t    color;
  } cmd_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic init_busy;
  } front_stat_t;

endpackage

// ===== design/dbf_req_if.sv =====
// Request channel: valid/ready handshake carrying one blit request.
// Depends on dbf_pkg for field widths.
interface dbf_req_if;
  logic                              valid;
  logic                              ready;
  logic [dbf_pkg::REQ_W-1:0]         req_type;
  logic signed [dbf_pkg::POS_W-1:0]  pos_x;
  logic signed [dbf_pkg::POS_W-1:0]  pos_y;
  logic [dbf_pkg::OFF_W-1:0]         offset_x;
  logic [dbf_pkg::OFF_W-1:0]         offset_y;
  logic [dbf_pkg::COLOR_W-1:0]       color;

  modport source (output valid, req_type, pos_x, pos_y, offset_x, offset_y, color,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, offset_x, offset_y, color,
                output ready);
endinterface

// ===== design/dbf_res_if.sv =====
// Result channel: valid/ready handshake carrying one scan-step result.
// Depends on dbf_pkg for field widths.
interface dbf_res_if;
  logic                           valid;
  logic                           ready;
  logic                           write_valid;
  logic [dbf_pkg::OUT_ADDR_W-1:0] write_addr;
  logic [dbf_pkg::COLOR_W-1:0]    write_color;
  logic                           scan_done;

  modport source (output valid, write_valid, write_addr, write_color, scan_done,
                  input ready);
  modport sink (input valid, write_valid, write_addr, write_color, scan_done,
                output ready);
endinterface

// ===== design/dbf_front.sv =====
// Front end: accepts requests, clips and color-keys them, forms screen addresses.
// Depends on dbf_pkg and dbf_req_if; feeds dbf_queue.
module dbf_front (
  dbf_req_if.sink            req,
  input  dbf_pkg::front_stat_t stat,
  output logic               push,
  output dbf_pkg::cmd_t      cmd
);

  logic signed [dbf_pkg::SUM_W-1:0] col_s;
  logic signed [dbf_pkg::SUM_W-1:0] row_s;
  logic                             is_sprite;
  logic                             on_screen;
  logic                             sprite_ok;
  logic                             keep;
  logic [dbf_pkg::COL_W-1:0]        col_u;
  logic [dbf_pkg::ROW_W-1:0]        row_u;
  logic [dbf_pkg::OFF_W:0]          side_lim;

  assign req.ready = !stat.full && !stat.init_busy;
  assign is_sprite = (req.req_type == dbf_pkg::REQ_SPRITE);
  assign side_lim  = (dbf_pkg::OFF_W + 1)'(dbf_pkg::SPRITE_SIDE_MAX);

  // Add the sprite offset to the origin; plain pixels use the origin as is.
  always_comb begin
    col_s = dbf_pkg::SUM_W'(req.pos_x);
    row_s = dbf_pkg::SUM_W'(req.pos_y);
    if (is_sprite) begin
      col_s = col_s + $signed({{(dbf_pkg::SUM_W - dbf_pkg::OFF_W){1'b0}}, req.offset_x});
      row_s = row_s + $signed({{(dbf_pkg::SUM_W - dbf_pkg::OFF_W){1'b0}}, req.offset_y});
    end
  end

  assign on_screen = !col_s[dbf_pkg::SUM_W-1] && !row_s[dbf_pkg::SUM_W-1]
                  && ($unsigned(col_s) < dbf_pkg::SUM_W'(dbf_pkg::SCREEN_COLUMNS))
                  && ($unsigned(row_s) < dbf_pkg::SUM_W'(dbf_pkg::SCREEN_ROWS));

  assign sprite_ok = (req.color != dbf_pkg::KEY_COLOR)
                  && ({1'b0, req.offset_x} < side_lim)
                  && ({1'b0, req.offset_y} < side_lim);

  assign col_u = dbf_pkg::COL_W'($unsigned(col_s));
  assign row_u = dbf_pkg::ROW_W'($unsigned(row_s));

  // Classify; drop clipped pixels and keyed or oversized sprite pixels here.
  always_comb begin
    cmd.color = req.color;
    cmd.addr  = dbf_pkg::pix_addr_t'(dbf_pkg::pix_addr_t'(row_u)
                  * dbf_pkg::pix_addr_t'(dbf_pkg::SCREEN_COLUMNS))
              + dbf_pkg::pix_addr_t'(col_u);
    unique case (req.req_type)
      dbf_pkg::REQ_CLEAR: begin
        cmd.op = dbf_pkg::CMD_CLEAR;
        keep   = 1'b1;
      end
      dbf_pkg::REQ_PIXEL: begin
        cmd.op = dbf_pkg::CMD_PIXEL;
        keep   = on_screen;
      end
      dbf_pkg::REQ_SPRITE: begin
        cmd.op = dbf_pkg::CMD_PIXEL;
        keep   = on_screen && sprite_ok;
      end
      default: begin
        cmd.op = dbf_pkg::CMD_SCAN;
        keep   = 1'b1;
      end
    endcase
  end

  assign push = req.valid && req.ready && keep;

endmodule

// ===== design/dbf_queue.sv =====
// Short command queue between the front end and the store engine.
// Depends on dbf_pkg and the assertion macro header.
`include "double_buffer_blit_diff_flush_core_assert.svh"

module dbf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dbf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output dbf_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  dbf_pkg::cmd_t                 slots [dbf_pkg::QUEUE_DEPTH];
  logic [dbf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dbf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dbf_pkg::QCNT_W-1:0]    count;

  assign not_empty = (count != '0);
  assign full      = (count == dbf_pkg::QCNT_W'(dbf_pkg::QUEUE_DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dbf_pkg::QPTR_W'(dbf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dbf_pkg::QPTR_W'(dbf_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  `DBF_ASSERT_SAME(a_no_push_full, push, !full || pop, "push into full queue")
  `DBF_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count lost a push")

endmodule

// ===== design/dbf_back.sv =====
// Store engine: owns the draw and shown pixel memories, runs fills and scan steps.
// Depends on dbf_pkg, dbf_res_if and the assertion macro header.
`include "double_buffer_blit_diff_flush_core_assert.svh"

module dbf_back (
  input  logic          clk,
  input  logic          rst,
  input  dbf_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          pop,
  output logic          init_busy,
  dbf_res_if.source     res
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]         state;
  dbf_pkg::pix_addr_t sweep_ptr;
  dbf_pkg::color_t    fill_color;
  logic               fill_both;
  dbf_pkg::pix_addr_t scan_pointer;
  dbf_pkg::pix_addr_t scan_addr;
  dbf_pkg::pix_addr_t scan_a;
  dbf_pkg::pix_addr_t rd_addr;
  dbf_pkg::color_t    rd_draw;
  dbf_pkg::color_t    rd_shown;
  logic               out_valid;
  logic               out_free;
  logic               out_load;
  logic               differ;
  logic               last;

  dbf_pkg::color_t    draw_mem  [dbf_pkg::PIXEL_COUNT];
  dbf_pkg::color_t    shown_mem [dbf_pkg::PIXEL_COUNT];

  logic               draw_we;
  dbf_pkg::pix_addr_t draw_wa;
  dbf_pkg::color_t    draw_wd;
  logic               shown_we;
  dbf_pkg::pix_addr_t shown_wa;
  dbf_pkg::color_t    shown_wd;

  assign init_busy = (state == ST_FILL) && fill_both;
  assign pop       = (state == ST_IDLE) && cmd_valid;
  assign scan_a    = (scan_pointer > dbf_pkg::LAST_ADDR) ? '0 : scan_pointer;
  assign rd_addr   = (state == ST_IDLE) ? scan_a : scan_addr;
  assign out_free  = !out_valid || res.ready;
  assign out_load  = (state == ST_SCAN) && out_free;
  assign differ    = (rd_draw != rd_shown);
  assign last      = (scan_addr == dbf_pkg::LAST_ADDR);

  // Memory write ports: fill sweeps win, then single pixel or write-back.
  always_comb begin
    draw_we  = (state == ST_FILL) || (pop && (cmd.op == dbf_pkg::CMD_PIXEL));
    draw_wa  = (state == ST_FILL) ? sweep_ptr : cmd.addr;
    draw_wd  = (state == ST_FILL) ? fill_color : cmd.color;
    shown_we = init_busy || (out_load && differ);
    shown_wa = (state == ST_FILL) ? sweep_ptr : scan_addr;
    shown_wd = (state == ST_FILL) ? fill_color : rd_draw;
  end

  always_ff @(posedge clk) begin
    if (draw_we) begin
      draw_mem[draw_wa] <= draw_wd;
    end
    rd_draw <= draw_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[shown_wa] <= shown_wd;
    end
    rd_shown <= shown_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      sweep_ptr    <= '0;
      fill_color   <= dbf_pkg::KEY_COLOR;
      fill_both    <= 1'b1;
      scan_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (sweep_ptr == dbf_pkg::LAST_ADDR) begin
            state     <= ST_IDLE;
            sweep_ptr <= '0;
            fill_both <= 1'b0;
          end else begin
            sweep_ptr <= sweep_ptr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop && (cmd.op == dbf_pkg::CMD_CLEAR)) begin
            fill_color <= cmd.color;
            state      <= ST_FILL;
          end else if (pop && (cmd.op == dbf_pkg::CMD_SCAN)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            state        <= ST_IDLE;
            scan_pointer <= last ? '0 : scan_addr + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scan_addr <= scan_a;
    end
    if (out_load) begin
      res.write_valid <= differ;
      res.write_addr  <= differ ? dbf_pkg::out_addr_t'(scan_addr) : '0;
      res.write_color <= differ ? rd_draw : '0;
      res.scan_done   <= last;
    end
  end

  assign res.valid = out_valid;

  `DBF_ASSERT_SAME(a_quiet_no_change, res.valid && !res.write_valid, res.write_addr == '0 && res.write_color == '0, "unchanged step carries data")
  `DBF_ASSERT_SAME(a_done_at_end, res.valid && res.scan_done && res.write_valid, res.write_addr == dbf_pkg::out_addr_t'(dbf_pkg::LAST_ADDR), "done flagged off the last address")
  `DBF_ASSERT_ALWAYS(a_ptr_range, scan_pointer <= dbf_pkg::LAST_ADDR, "scan pointer out of range")

endmodule

// ===== design/double_buffer_blit_diff_flush_core.sv =====
// Top level of the double-buffered pixel store with difference flush.
// Depends on dbf_pkg, dbf_req_if, dbf_res_if, dbf_front, dbf_queue, dbf_back.
//
// Keeps a draw buffer and a shown buffer of SCREEN_COLUMNS x SCREEN_ROWS 8-bit
// pixels, both 255 after reset. A clear request fills the draw buffer with one
// color, a pixel request writes one clipped pixel, a sprite pixel adds its
// offset to the origin, skips color 255 and clips. A scan request compares both
// buffers at the internal scan pointer and returns one result transaction: on a
// difference it reports the address and new color and copies the pixel into the
// shown buffer; scan_done marks the last address, after which the pointer wraps.
// Timing: the front end takes one request per cycle, while the queue is not full
// and the reset pass is done, into a four-entry command queue. Pixel and sprite
// requests are written to the draw memory as they are popped; clipped and keyed
// ones are dropped in the front end and never reach the queue. A scan step does a
// registered read of both memories, then compare and write-back, and waits while
// the result register is not drained. A clear walks all PIXEL_COUNT addresses
// (307200 at 640x480) of the draw memory one per cycle. After reset a clearing
// pass writes 255 to both memories; req.ready stays low until it completes.
module double_buffer_blit_diff_flush_core (
  input  logic     clk,
  input  logic     rst,
  dbf_req_if.sink  req,
  dbf_res_if.source res
);

  logic                 push;
  dbf_pkg::cmd_t        push_cmd;
  dbf_pkg::cmd_t        head;
  logic                 not_empty;
  logic                 pop;
  dbf_pkg::front_stat_t stat;
  logic                 q_full;
  logic                 init_busy;

  // Hold requests while the queue is full or the reset pass is running.
  assign stat.full      = q_full;
  assign stat.init_busy = init_busy;

  dbf_front u_front (
    .req  (req),
    .stat (stat),
    .push (push),
    .cmd  (push_cmd)
  );

  dbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (q_full)
  );

  dbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head),
    .cmd_valid (not_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .res       (res)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for double_buffer_blit_diff_flush_core.
// Depends on dbf_pkg, dbf_req_if, dbf_res_if and the core RTL.
// Stimulus: directed blits, a full clear and random blits around the scan pointer.
`timescale 1ns / 100ps

module tb;
  import dbf_pkg::*;

  // One blit request as it travels on the request channel.
  typedef struct packed {
    req_type_t                 kind;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic [OFF_W-1:0]          ox;
    logic [OFF_W-1:0]          oy;
    color_t                    color;
  } blit_req_t;

  // One scan-step outcome: a display write or a quiet step.
  typedef struct packed {
    logic      wr;
    out_addr_t addr;
    color_t    color;
    logic      done;
  } flush_write_t;

  localparam int RANDOM_BLITS = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 32;
  localparam int NEAR_SPAN    = 48;

  logic clk;
  logic rst;

  dbf_req_if req_ch ();
  dbf_res_if res_ch ();

  double_buffer_blit_diff_flush_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Shadow copies of both frame stores and the scan pointer.
  color_t      draw_img  [PIXEL_COUNT];
  color_t      shown_img [PIXEL_COUNT];
  int unsigned scan_at;

  flush_write_t flushes_due [$];   // display writes still to come, oldest first
  blit_req_t    blit_backlog [$];  // requests waiting for the driver

  // Where the scan pointer will be when the next queued request is applied.
  // Lets the generator aim pixels just ahead of the scan.
  int unsigned gen_scan_at;

  int send_idle_pct;
  int take_idle_pct;
  bit hold_request;
  bit hold_started;
  int hold_left;

  int reqs_queued;
  int reqs_taken;
  int scans_seen;
  int writes_seen;
  int bad_flushes;

  blit_req_t    drv_blit;
  blit_req_t    taken_blit;
  flush_write_t got_flush;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop; the slowest legal run needs well under a third of this.
  initial begin
    #100_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Write one pixel into the draw image; drop it if it lands off screen.
  function automatic void plot(input int col, input int row, input color_t c);
    if (col >= 0 && col < SCREEN_COLUMNS && row >= 0 && row < SCREEN_ROWS)
      draw_img[row * SCREEN_COLUMNS + col] = c;
  endfunction

  // Apply one accepted request to the shadow stores and queue the display
  // write that a scan step produces.
  task automatic apply_blit(input blit_req_t r);
    int unsigned  a;
    flush_write_t w;
    case (r.kind)
      REQ_CLEAR: begin
        for (int i = 0; i < PIXEL_COUNT; i++) draw_img[i] = r.color;
      end
      REQ_PIXEL: begin
        // A plain pixel keeps the key color; only clipping drops it.
        plot(int'($signed(r.px)), int'($signed(r.py)), r.color);
      end
      REQ_SPRITE: begin
        // Drop key-colored sprite pixels and offsets past the sprite side.
        if (r.color != KEY_COLOR && r.ox < SPRITE_SIDE_MAX && r.oy < SPRITE_SIDE_MAX)
          plot(int'($signed(r.px)) + int'(r.ox), int'($signed(r.py)) + int'(r.oy), r.color);
      end
      default: begin
        a = scan_at;
        if (a >= PIXEL_COUNT) a = 0;
        w.done = (a == PIXEL_COUNT - 1);
        if (draw_img[a] != shown_img[a]) begin
          w.wr    = 1'b1;
          w.addr  = out_addr_t'(a);
          w.color = draw_img[a];
          shown_img[a] = draw_img[a];
        end else begin
          w.wr    = 1'b0;
          w.addr  = '0;
          w.color = '0;
        end
        flushes_due.push_back(w);
        scan_at = w.done ? 0 : a + 1;
      end
    endcase
  endtask

  task automatic flag_flush(input string why, input flush_write_t want,
                            input flush_write_t got);
    bad_flushes++;
    if (bad_flushes <= 10)
      $display("%0t %s: want wr=%0b addr=%0d color=%0d done=%0b, %s",
               $realtime, why, want.wr, want.addr, want.color, want.done,
               $sformatf("got wr=%0b addr=%0d color=%0d done=%0b",
                         got.wr, got.addr, got.color, got.done));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int rnd_pos();
    return int'($urandom_range(2047)) - 1024;
  endfunction

  task automatic queue_blit(input req_type_t kind, input int px, input int py,
                            input int ox, input int oy, input int color);
    blit_req_t r;
    r.kind  = kind;
    r.px    = px[POS_W-1:0];
    r.py    = py[POS_W-1:0];
    r.ox    = ox[OFF_W-1:0];
    r.oy    = oy[OFF_W-1:0];
    r.color = color[COLOR_W-1:0];
    blit_backlog.push_back(r);
    reqs_queued++;
    if (kind == REQ_SCAN)
      gen_scan_at = (gen_scan_at == PIXEL_COUNT - 1) ? 0 : gen_scan_at + 1;
  endtask

  // Scan steps ignore their payload; fill it with noise.
  task automatic queue_scan();
    queue_blit(REQ_SCAN, rnd_pos(), rnd_pos(), $urandom_range(255), $urandom_range(255),
               $urandom_range(255));
  endtask

  // Mostly aim pixels and sprites a little ahead of the scan pointer so the
  // scans actually find changes; the rest lands anywhere, mostly off screen.
  task automatic queue_random_blits(input int count);
    int     pick;
    int     a;
    int     col;
    int     row;
    int     ox;
    int     oy;
    int     c;
    bit     near;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      c    = ($urandom_range(99) < 15) ? int'(KEY_COLOR) : int'($urandom_range(255));
      a    = (gen_scan_at + $urandom_range(NEAR_SPAN)) % PIXEL_COUNT;
      col  = a % SCREEN_COLUMNS;
      row  = a / SCREEN_COLUMNS;
      near = ($urandom_range(99) < 80);
      ox   = $urandom_range(255);
      oy   = $urandom_range(255);
      if (pick < 40)
        queue_scan();
      else if (pick < 70) begin
        if (near) queue_blit(REQ_PIXEL, col, row, ox, oy, c);
        else      queue_blit(REQ_PIXEL, rnd_pos(), rnd_pos(), ox, oy, c);
      end else begin
        // Back the origin off by the offset so origin plus offset hits the target.
        if (near) queue_blit(REQ_SPRITE, col - ox, row - oy, ox, oy, c);
        else      queue_blit(REQ_SPRITE, rnd_pos(), rnd_pos(), ox, oy, c);
      end
    end
  endtask

  // Hold off until every queued request is taken and every write has arrived.
  task automatic wait_flushed();
    while (reqs_taken != reqs_queued || flushes_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next backlog request; hold it until it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (blit_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_blit = blit_backlog.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= drv_blit.kind;
        req_ch.pos_x    <= drv_blit.px;
        req_ch.pos_y    <= drv_blit.py;
        req_ch.offset_x <= drv_blit.ox;
        req_ch.offset_y <= drv_blit.oy;
        req_ch.color    <= drv_blit.color;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the command
  // queue fill up and back-pressure the request channel.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each request transaction, check each result
  // transaction against the oldest expected write.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        taken_blit.kind  = req_ch.req_type;
        taken_blit.px    = req_ch.pos_x;
        taken_blit.py    = req_ch.pos_y;
        taken_blit.ox    = req_ch.offset_x;
        taken_blit.oy    = req_ch.offset_y;
        taken_blit.color = req_ch.color;
        reqs_taken++;
        apply_blit(taken_blit);
      end
      if (res_ch.valid && res_ch.ready) begin
        got_flush.wr    = res_ch.write_valid;
        got_flush.addr  = res_ch.write_addr;
        got_flush.color = res_ch.write_color;
        got_flush.done  = res_ch.scan_done;
        scans_seen++;
        if (got_flush.wr === 1'b1) writes_seen++;
        if (flushes_due.size() == 0) begin
          flag_flush("result with no scan pending", '0, got_flush);
        end else if (got_flush.wr    !== flushes_due[0].wr    ||
                     got_flush.addr  !== flushes_due[0].addr  ||
                     got_flush.color !== flushes_due[0].color ||
                     got_flush.done  !== flushes_due[0].done) begin
          flag_flush("scan result mismatch", flushes_due.pop_front(), got_flush);
        end else begin
          void'(flushes_due.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_CLEAR;
    req_ch.pos_x    = '0;
    req_ch.pos_y    = '0;
    req_ch.offset_x = '0;
    req_ch.offset_y = '0;
    req_ch.color    = '0;
    res_ch.ready    = 1'b0;

    send_idle_pct = 8;
    take_idle_pct = 58;
    hold_request  = 1'b0;
    hold_started  = 1'b0;
    hold_left     = 0;
    reqs_queued   = 0;
    reqs_taken    = 0;
    scans_seen    = 0;
    writes_seen   = 0;
    bad_flushes   = 0;
    scan_at       = 0;
    gen_scan_at   = 0;
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      draw_img[i]  = KEY_COLOR;
      shown_img[i] = KEY_COLOR;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The scan pointer starts at address 0, so the first
    // scans land on the pixels written along row 0.
    queue_scan();                                          // both stores equal
    queue_blit(REQ_PIXEL, 1, 0, 0, 0, 0);                  // lowest color
    queue_blit(REQ_PIXEL, 2, 0, 0, 0, 255);                // key color stored, no change
    queue_blit(REQ_SPRITE, -1, 0, 4, 0, 8'hA5);            // negative origin pulled on screen
    queue_blit(REQ_SPRITE, 0, 0, 3, 0, 255);               // key color must not erase it
    repeat (5) queue_scan();                               // addresses 1..5
    queue_blit(REQ_CLEAR, rnd_pos(), rnd_pos(), 0, 0, 8'h5A);
    // Clipping: each of these would alias onto a real pixel if the
    // address were formed without range checks.
    queue_blit(REQ_PIXEL, -1, 1, 0, 0, 7);
    queue_blit(REQ_PIXEL, 640, 0, 0, 0, 7);
    queue_blit(REQ_PIXEL, 0, -1, 0, 0, 7);
    queue_blit(REQ_PIXEL, 0, 480, 0, 0, 7);
    queue_blit(REQ_PIXEL, -1024, -1024, 0, 0, 7);
    queue_blit(REQ_PIXEL, 1023, 1023, 0, 0, 7);
    queue_blit(REQ_SPRITE, -1024, -1024, 255, 255, 1);
    queue_blit(REQ_SPRITE, 1023, 1023, 0, 0, 1);
    queue_blit(REQ_SPRITE, 600, 0, 40, 0, 2);              // one past the right edge
    queue_blit(REQ_SPRITE, 384, 224, 255, 255, 8'h3C);     // largest offsets hit the last pixel
    queue_blit(REQ_PIXEL, 7, 0, 0, 0, 255);                // undo the clear at address 7
    repeat (3) queue_scan();                               // addresses 6..8
    wait_flushed();

    // Random part, slow receiver; stall it hard once while requests pile up.
    queue_random_blits(RANDOM_BLITS / 3);
    hold_request = 1'b1;
    wait_flushed();

    // Random part, slow sender.
    send_idle_pct = 58;
    take_idle_pct = 8;
    queue_random_blits(RANDOM_BLITS / 3);
    wait_flushed();

    // Random part at full rate.
    send_idle_pct = 0;
    take_idle_pct = 0;
    queue_random_blits(RANDOM_BLITS - 2 * (RANDOM_BLITS / 3));
    wait_flushed();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (flushes_due.size() != 0) begin
      bad_flushes += flushes_due.size();
      $display("%0d scan results never arrived", flushes_due.size());
    end

    $display("Ran %0d requests: %0d scan steps, %0d changed pixels sent to the display.",
             reqs_taken, scans_seen, writes_seen);
    $display("Exercised clipping, color key, a full clear, a long result stall; %0d mismatches.",
             bad_flushes);
    if (bad_flushes == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dbf_pkg.sv
design/dbf_req_if.sv
design/dbf_res_if.sv
design/dbf_front.sv
design/dbf_queue.sv
design/dbf_back.sv
design/double_buffer_blit_diff_flush_core.sv
tb/sv/tb.sv
